@@ rtl/core/iiwb_pkg.sv @@
// ----------------------------------------------------------------------------
// iiwb_pkg
// Shared types and constants for the bordered integral image block.
// ----------------------------------------------------------------------------
package iiwb_pkg;

  // Field and register widths
  localparam int PIXEL_W     = 16;
  localparam int SUM_W       = 32;
  localparam int FRAME_DIM_W = 11;
  localparam int BORDER_W    = 6;
  localparam int CFG_DATA_W  = FRAME_DIM_W;
  localparam int CFG_INDEX_W = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BORDER_SIZE  = 2'd2;

  // Register reset values (before clamping)
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_BORDER = 0;

  // What a padded position produces
  typedef enum logic [1:0] {
    KIND_ZERO,      // top or left padding
    KIND_INTERIOR,  // source pixel: accumulate and add the value above
    KIND_RIGHT,     // right padding: repeat last interior value of the row
    KIND_BOTTOM     // bottom padding: repeat the line store
  } kind_t;

  // Item held between the position stage and the sum stage
  typedef struct packed {
    kind_t                      kind;
    logic                       col_first;   // column zero: row sum restarts
    logic                       above_valid; // a row lies above in the source
    logic                       write_line;  // row of the interior band
    logic                       last;        // final position of the frame
    logic signed [PIXEL_W-1:0]  pixel;
  } item_t;

endpackage

@@ rtl/core/iiwb_line_mem.sv @@
// ----------------------------------------------------------------------------
// iiwb_line_mem
// One-row line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iiwb_line_mem #(
  parameter int DEPTH  = 1088,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/integral_image_with_border_top.sv @@
// ----------------------------------------------------------------------------
// integral_image_with_border_top
// Streaming integral image over a padded frame, one position per item.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless the result side stalls, and gives
// one result per item, in raster order over the padded frame of
// (width + 2*border) by (height + 2*border) positions. Each item passes the
// sum stage register and then the output register. A stall on the result
// side holds at most two items inside before the pixel side stalls. The rate
// is set by the line store: one read and one write per clock, the read for a
// column issued when its item is accepted and the write done one stage later;
// when the padded width is one the pending write is forwarded to the read. The
// line store needs no clearing after reset, since every column is written in
// the first interior row of a frame before it is read. Any write to one of the
// three registers restarts the frame at the top left corner; the line store
// keeps its contents. Width and height of zero count as one; values above the
// limits are clamped, the border only after its cut to the low BORDER_W bits.
// ----------------------------------------------------------------------------
module integral_image_with_border_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_BORDER = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write_en,
  input  logic [iiwb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [iiwb_pkg::CFG_DATA_W-1:0]     cfg_data,
  // pixel items
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic signed [iiwb_pkg::PIXEL_W-1:0] pixel,
  // result items
  output logic                                sum_valid,
  input  logic                                sum_stall,
  output logic signed [iiwb_pkg::SUM_W-1:0]   sum_value,
  output logic                                in_border,
  output logic                                frame_last
);
  import iiwb_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH + 2 * MAX_BORDER;
  localparam int AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int PW_W = $clog2(LINE_DEPTH + 1);
  localparam int PH_W = $clog2(MAX_HEIGHT + 2 * MAX_BORDER + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int BW   = (MAX_BORDER > 0) ? $clog2(MAX_BORDER + 1) : 1;
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
  localparam int RST_B = (RESET_BORDER > MAX_BORDER) ? MAX_BORDER : RESET_BORDER;

  // Clamped geometry and derived bounds
  logic [WW-1:0]   eff_w, eff_w_next;
  logic [HW-1:0]   eff_h, eff_h_next;
  logic [BW-1:0]   eff_b, eff_b_next;
  logic [PW_W-1:0] pw, b_plus_w;
  logic [PH_W-1:0] ph, b_plus_h;
  logic            restart;

  // Position stage
  logic [AW-1:0]   col;
  logic [PH_W-1:0] row;
  logic [PW_W-1:0] col_ext, col_inc;
  logic [PH_W-1:0] row_inc;
  logic [PW_W-1:0] b_col;
  logic [PH_W-1:0] b_row;
  logic            accept;
  item_t           item_in;

  // Sum stage
  logic            s1_valid;
  item_t           s1;
  logic [AW-1:0]   s1_col;
  logic            s1_go;
  logic [SUM_W-1:0] row_accum, last_interior;
  logic [SUM_W-1:0] acc_base, acc_add, mem_val, above, inter_sum, sum_s1;
  logic [SUM_W-1:0] pix_ext;
  logic            fwd_hit;
  logic [SUM_W-1:0] fwd_data;
  logic [SUM_W-1:0] rd_data;
  logic            line_wr;

  // Clamp register writes
  always_comb begin
    eff_w_next = eff_w;
    eff_h_next = eff_h;
    eff_b_next = eff_b;
    restart    = 1'b0;
    if (cfg_write_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          restart = 1'b1;
          if (cfg_data == '0) eff_w_next = WW'(1);
          else if (32'(cfg_data) > MAX_WIDTH) eff_w_next = WW'(MAX_WIDTH);
          else eff_w_next = WW'(cfg_data);
        end
        REG_FRAME_HEIGHT: begin
          restart = 1'b1;
          if (cfg_data == '0) eff_h_next = HW'(1);
          else if (32'(cfg_data) > MAX_HEIGHT) eff_h_next = HW'(MAX_HEIGHT);
          else eff_h_next = HW'(cfg_data);
        end
        REG_BORDER_SIZE: begin
          restart = 1'b1;
          if (32'(cfg_data[BORDER_W-1:0]) > MAX_BORDER) eff_b_next = BW'(MAX_BORDER);
          else eff_b_next = BW'(cfg_data[BORDER_W-1:0]);
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // Geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w    <= WW'(RST_W);
      eff_h    <= HW'(RST_H);
      eff_b    <= BW'(RST_B);
      pw       <= PW_W'(RST_W + 2 * RST_B);
      ph       <= PH_W'(RST_H + 2 * RST_B);
      b_plus_w <= PW_W'(RST_W + RST_B);
      b_plus_h <= PH_W'(RST_H + RST_B);
    end else begin
      eff_w    <= eff_w_next;
      eff_h    <= eff_h_next;
      eff_b    <= eff_b_next;
      pw       <= PW_W'(eff_w_next) + (PW_W'(eff_b_next) << 1);
      ph       <= PH_W'(eff_h_next) + (PH_W'(eff_b_next) << 1);
      b_plus_w <= PW_W'(eff_w_next) + PW_W'(eff_b_next);
      b_plus_h <= PH_W'(eff_h_next) + PH_W'(eff_b_next);
    end
  end

  // Handshake: the sum stage moves when the output register is free
  assign s1_go       = s1_valid && (!sum_valid || !sum_stall);
  assign pixel_stall = s1_valid && !s1_go;
  assign accept      = pixel_valid && !pixel_stall;

  // Classify the current padded position
  assign col_ext = PW_W'(col);
  assign col_inc = col_ext + PW_W'(1);
  assign row_inc = row + PH_W'(1);
  assign b_col   = PW_W'(eff_b);
  assign b_row   = PH_W'(eff_b);

  always_comb begin
    item_in.kind        = KIND_ZERO;
    item_in.write_line  = 1'b0;
    item_in.col_first   = (col == '0);
    item_in.above_valid = (row > b_row);
    item_in.last        = (col_inc == pw) && (row_inc == ph);
    item_in.pixel       = pixel;
    if (row < b_row) begin
      item_in.kind = KIND_ZERO;
    end else if (row < b_plus_h) begin
      item_in.write_line = 1'b1;
      if (col_ext < b_col) item_in.kind = KIND_ZERO;
      else if (col_ext < b_plus_w) item_in.kind = KIND_INTERIOR;
      else item_in.kind = KIND_RIGHT;
    end else begin
      item_in.kind = KIND_BOTTOM;
    end
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_inc == pw) begin
        col <= '0;
        row <= (row_inc == ph) ? '0 : row_inc;
      end else begin
        col <= AW'(col_inc);
      end
    end
  end

  // Sum stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= item_in;
      s1_col   <= col;
      // bypass the write that lands on the same column at this edge
      fwd_hit  <= s1_go && s1.write_line && (s1_col == col);
      fwd_data <= sum_s1;
    end
  end

  // Line store
  assign line_wr = s1_go && s1.write_line;

  iiwb_line_mem #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (AW),
    .DATA_W (SUM_W)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (s1_col),
    .wr_data (sum_s1),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data)
  );

  // Sum arithmetic
  assign pix_ext   = {{(SUM_W - PIXEL_W){s1.pixel[PIXEL_W-1]}}, s1.pixel};
  assign mem_val   = fwd_hit ? fwd_data : rd_data;
  assign above     = s1.above_valid ? mem_val : '0;
  assign acc_base  = s1.col_first ? '0 : row_accum;
  assign acc_add   = acc_base + pix_ext;
  assign inter_sum = acc_add + above;

  always_comb begin
    case (s1.kind)
      KIND_ZERO:     sum_s1 = '0;
      KIND_INTERIOR: sum_s1 = inter_sum;
      KIND_RIGHT:    sum_s1 = last_interior;
      KIND_BOTTOM:   sum_s1 = mem_val;
      default:       sum_s1 = '0;
    endcase
  end

  // Row sum and last interior value
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_accum     <= '0;
      last_interior <= '0;
    end else if (s1_go) begin
      if (s1.last) begin
        row_accum     <= '0;
        last_interior <= '0;
      end else if (s1.kind == KIND_INTERIOR) begin
        row_accum     <= acc_add;
        last_interior <= inter_sum;
      end else begin
        row_accum     <= acc_base;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (s1_go) begin
      sum_valid <= 1'b1;
    end else if (!sum_stall) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      sum_value  <= sum_s1;
      in_border  <= (s1.kind != KIND_INTERIOR);
      frame_last <= s1.last;
    end
  end

  // Checks
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    col_ext < pw)
    else $error("column counter beyond padded width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    row < ph)
    else $error("row counter beyond padded height");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1))
    else $error("sum stage lost a held item");

  a_fwd_narrow: assert property (@(posedge clk) disable iff (rst)
    s1_valid && fwd_hit |-> pw == PW_W'(1))
    else $error("line store bypass taken with padded width above one");

endmodule
